// ===== src/bsr_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsr_pkg
// Widths, the tolerance shift and the state type shared by the bisection square root unit.
// ----------------------------------------------------------------------------
package bsr_pkg;

  localparam int RAD_BITS  = 26;
  localparam int ROOT_BITS = 13;
  localparam int TOL_SHIFT = 8;

  typedef logic [RAD_BITS-1:0]  rad_t;
  typedef logic [ROOT_BITS-1:0] root_t;

  typedef logic [1:0] state_t;

endpackage

// ===== src/bsr_in_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsr_in_if
// Request channel: radicand and root bound with valid/ready handshake.
// ----------------------------------------------------------------------------
interface bsr_in_if;
  import bsr_pkg::*;

  logic  valid;
  logic  ready;
  rad_t  radicand;
  root_t root_bound;

  modport source (output valid, output radicand, output root_bound, input ready);
  modport sink   (input valid, input radicand, input root_bound, output ready);
endinterface

// ===== src/bsr_out_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsr_out_if
// Result channel: approximate root with valid/ready handshake.
// ----------------------------------------------------------------------------
interface bsr_out_if;
  import bsr_pkg::*;

  logic  valid;
  logic  ready;
  root_t root;

  modport source (output valid, output root, input ready);
  modport sink   (input valid, input root, output ready);
endinterface

// ===== src/bisection_square_root_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bisection_square_root_unit
// Integer square root by bisection over [0, root_bound], one shared
// 13x13 squarer and one magnitude compare reused each step.
// ----------------------------------------------------------------------------
// Sequence: each step squares the trial in ST_MUL and then compares it in ST_CMP; a
//   finished result that cannot leave yet waits in ST_HOLD.
// Throughput: one transaction at a time; the next request is taken as soon as
//   the sequencer is idle, even while the last result still waits at the output.
// Reset: synchronous, active high; clears the sequencer and the output valid.
module bisection_square_root_unit #(
  parameter int MAX_STEPS = 20
) (
  input logic      clk,
  input logic      rst,
  bsr_in_if.sink   sample,
  bsr_out_if.source result
);
  import bsr_pkg::*;

  localparam int             SW         = $clog2(MAX_STEPS + 1);
  localparam logic [SW-1:0]  STEP_LIMIT = SW'(MAX_STEPS);

  localparam state_t ST_IDLE = 2'd0;
  localparam state_t ST_MUL  = 2'd1;
  localparam state_t ST_CMP  = 2'd2;
  localparam state_t ST_HOLD = 2'd3;

  state_t        state, state_next;
  rad_t          rad;
  rad_t          tol;
  root_t         trial, trial_next;
  root_t         lo, lo_next;
  root_t         hi, hi_next;
  root_t         bound;
  rad_t          sq;
  logic [SW-1:0] steps, steps_next;
  logic          out_valid, out_valid_next;
  root_t         out_root;

  logic          below;
  rad_t          absd;
  logic          finish;
  logic          out_free;
  logic [ROOT_BITS:0] mid_sum;

  assign sample.ready = (state == ST_IDLE);
  assign result.valid = out_valid;
  assign result.root  = out_root;
  assign out_free     = !out_valid || result.ready;

  always_comb begin
    below   = (sq < rad);
    absd    = below ? (rad - sq) : (sq - rad);
    finish  = (absd <= tol) || (steps == STEP_LIMIT);
    mid_sum = below ? ({1'b0, trial} + {1'b0, hi}) : ({1'b0, trial} + {1'b0, lo});
  end

  always_comb begin
    state_next     = state;
    trial_next     = trial;
    lo_next        = lo;
    hi_next        = hi;
    steps_next     = steps;
    out_valid_next = out_valid && !result.ready;
    case (state)
      ST_IDLE: begin
        if (sample.valid) begin
          trial_next = sample.root_bound >> 1;
          lo_next    = '0;
          hi_next    = sample.root_bound;
          steps_next = '0;
          state_next = ST_MUL;
        end
      end
      ST_MUL: begin
        state_next = ST_CMP;
      end
      ST_CMP: begin
        if (finish) begin
          if (out_free) begin
            out_valid_next = 1'b1;
            state_next     = ST_IDLE;
          end else begin
            state_next = ST_HOLD;
          end
        end else begin
          steps_next = steps + 1'b1;
          trial_next = mid_sum[ROOT_BITS:1];
          if (below) begin
            lo_next = trial;
          end else begin
            hi_next = trial;
          end
          state_next = ST_MUL;
        end
      end
      ST_HOLD: begin
        if (out_free) begin
          out_valid_next = 1'b1;
          state_next     = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  // datapath, no reset needed
  always_ff @(posedge clk) begin
    trial <= trial_next;
    lo    <= lo_next;
    hi    <= hi_next;
    steps <= steps_next;
    if (state == ST_IDLE && sample.valid) begin
      rad   <= sample.radicand;
      tol   <= sample.radicand >> TOL_SHIFT;
      bound <= sample.root_bound;
    end
    // operands widened first so the full square is kept
    if (state == ST_MUL) begin
      sq <= rad_t'(trial) * rad_t'(trial);
    end
    if ((state == ST_CMP && finish && out_free) || (state == ST_HOLD && out_free)) begin
      out_root <= trial;
    end
  end

  // search window stays ordered and inside the bound
  a_window: assert property (@(posedge clk) disable iff (rst)
    (state == ST_MUL || state == ST_CMP) |-> (lo <= trial && trial <= hi && hi <= bound))
    else $error("bisection window out of order");

  a_steps: assert property (@(posedge clk) disable iff (rst)
    (state != ST_IDLE) |-> (steps <= STEP_LIMIT))
    else $error("step count beyond limit");

  a_start: assert property (@(posedge clk) disable iff (rst)
    (sample.valid && sample.ready) |=> (state == ST_MUL && steps == '0))
    else $error("accepted request did not start a search");

  a_result: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CMP && finish && out_free) |=> (out_valid && out_root == $past(trial)))
    else $error("finished search did not present its trial");

endmodule
